### design/bdgd_pkg.sv
// ----------------------------------------------------------------------------
// bdgd_pkg: shared types and constants for the button debounce detector
// Register map, reset values and the result word layout.
// ----------------------------------------------------------------------------
package bdgd_pkg;

    localparam int unsigned ADDR_W = 5;
    localparam int unsigned APB_DW = 32;
    localparam int unsigned REG_IDX_W = 3;

    // register indexes (byte address = 4 * index)
    localparam logic [REG_IDX_W-1:0] REG_ACTIVE_LEVEL   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_DEBOUNCE_MS    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_LONG_PRESS_MS  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_DOUBLE_CLICK_MS = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_EVENTS_ENABLE  = 3'd4;

    localparam logic        RST_ACTIVE_LEVEL    = 1'b0;
    localparam logic [9:0]  RST_DEBOUNCE_MS     = 10'd50;
    localparam logic [15:0] RST_LONG_PRESS_MS   = 16'd1000;
    localparam logic [15:0] RST_DOUBLE_CLICK_MS = 16'd300;
    localparam logic        RST_EVENTS_ENABLE   = 1'b1;

    localparam logic [15:0] SAT16 = 16'hFFFF;

    // op codes carried on s_tuser
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    localparam int unsigned IN_DATA_W  = 8;
    localparam int unsigned OUT_DATA_W = 152;

    // result word, last field in the lowest bits
    typedef struct packed {
        logic [1:0]  pad;
        logic [31:0] double_click_total;
        logic [31:0] long_press_total;
        logic [31:0] release_total;
        logic [31:0] press_total;
        logic [15:0] hold_ms;
        logic        button_down;
        logic        long_press_event;
        logic        double_click_event;
        logic        click_event;
        logic        released_event;
        logic        pressed_event;
    } result_t;

endpackage

### design/button_debounce_gesture_detector.sv
// ----------------------------------------------------------------------------
// button_debounce_gesture_detector: debounce and click / long-press detector
// One word per millisecond tick (or clear command) in, one status word out.
// ----------------------------------------------------------------------------
//  channel   dir  handshake            payload
//  s_*       in   s_tvalid / s_tready  s_tuser: op, s_tdata[0]: pin_level
//  m_*       out  m_tvalid / m_tready  m_tdata: events, state, hold, totals
//  apb       in   psel/penable/pready  five config registers at 4*index
//
//  One word per clock while the output is not stalled; a word's result passes
//  through the input register, then the result register, which offers it.
//  The rate is set by the state update between the two registers, which is combinational.
//  Reset (rst_n low) returns the registers to their reset values and clears
//  all detector state. A stalled output holds its word and the input register
//  keeps the next word; s_tready drops only when both are full.
// ----------------------------------------------------------------------------
module button_debounce_gesture_detector
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    // slave side
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [bdgd_pkg::IN_DATA_W-1:0]       s_tdata,   // [0] pin_level, [7:1] zero
    input  logic                                 s_tuser,   // [0] op
    // master side
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [0] pressed_event, [1] released_event, [2] click_event,
    // [3] double_click_event, [4] long_press_event, [5] button_down,
    // [21:6] hold_ms, [53:22] press_total, [85:54] release_total,
    // [117:86] long_press_total, [149:118] double_click_total, [151:150] zero
    output logic [bdgd_pkg::OUT_DATA_W-1:0]      m_tdata,
    // configuration
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [bdgd_pkg::ADDR_W-1:0]          paddr,
    input  logic [bdgd_pkg::APB_DW-1:0]          pwdata,
    output logic [bdgd_pkg::APB_DW-1:0]          prdata,
    output logic                                 pready
);
    import bdgd_pkg::*;

    // configuration registers
    logic        active_level_reg;
    logic [9:0]  debounce_ms_reg;
    logic [15:0] long_press_ms_reg;
    logic [15:0] double_click_ms_reg;
    logic        events_enable_reg;

    logic                 cfg_wr;
    logic [REG_IDX_W-1:0] cfg_idx;

    // input register
    logic in_valid_reg;
    logic in_op_reg;
    logic in_pin_reg;

    // detector state
    logic        prev_raw_reg,       prev_raw_next;
    logic        pending_raw_reg,    pending_raw_next;
    logic        stable_reg,         stable_next;
    logic [9:0]  deb_left_reg,       deb_left_next;
    logic        deb_armed_reg,      deb_armed_next;
    logic [15:0] long_left_reg,      long_left_next;
    logic        long_armed_reg,     long_armed_next;
    logic [15:0] since_press_reg,    since_press_next;
    logic [15:0] since_click_reg,    since_click_next;
    logic [31:0] press_cnt_reg,      press_cnt_next;
    logic [31:0] release_cnt_reg,    release_cnt_next;
    logic [31:0] long_cnt_reg,       long_cnt_next;
    logic [31:0] dclick_cnt_reg,     dclick_cnt_next;

    // output register
    logic    out_valid_reg;
    result_t out_reg;
    result_t res;

    logic        advance;
    logic        raw;
    logic        ev_p, ev_r, ev_c, ev_d, ev_l;
    logic [9:0]  deb_dec;
    logic [15:0] long_dec;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb
    begin
        case (cfg_idx)
            REG_ACTIVE_LEVEL:    prdata = {31'd0, active_level_reg};
            REG_DEBOUNCE_MS:     prdata = {22'd0, debounce_ms_reg};
            REG_LONG_PRESS_MS:   prdata = {16'd0, long_press_ms_reg};
            REG_DOUBLE_CLICK_MS: prdata = {16'd0, double_click_ms_reg};
            REG_EVENTS_ENABLE:   prdata = {31'd0, events_enable_reg};
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_level_reg    <= RST_ACTIVE_LEVEL;
            debounce_ms_reg     <= RST_DEBOUNCE_MS;
            long_press_ms_reg   <= RST_LONG_PRESS_MS;
            double_click_ms_reg <= RST_DOUBLE_CLICK_MS;
            events_enable_reg   <= RST_EVENTS_ENABLE;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_ACTIVE_LEVEL:    active_level_reg    <= pwdata[0];
                REG_DEBOUNCE_MS:     debounce_ms_reg     <= pwdata[9:0];
                REG_LONG_PRESS_MS:   long_press_ms_reg   <= pwdata[15:0];
                REG_DOUBLE_CLICK_MS: double_click_ms_reg <= pwdata[15:0];
                REG_EVENTS_ENABLE:   events_enable_reg   <= pwdata[0];
                default:             ;
            endcase
        end
    end

    // handshake: process the held word whenever the result slot frees up
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_op_reg  <= s_tuser;
            in_pin_reg <= s_tdata[0];
        end
    end

    assign raw      = (in_pin_reg == active_level_reg);
    assign deb_dec  = (deb_left_reg != 10'd0) ? deb_left_reg - 10'd1 : deb_left_reg;
    assign long_dec = (long_left_reg != 16'd0) ? long_left_reg - 16'd1 : long_left_reg;

    always_comb
    begin
        prev_raw_next    = prev_raw_reg;
        pending_raw_next = pending_raw_reg;
        stable_next      = stable_reg;
        deb_left_next    = deb_left_reg;
        deb_armed_next   = deb_armed_reg;
        long_left_next   = long_left_reg;
        long_armed_next  = long_armed_reg;
        since_press_next = since_press_reg;
        since_click_next = since_click_reg;
        press_cnt_next   = press_cnt_reg;
        release_cnt_next = release_cnt_reg;
        long_cnt_next    = long_cnt_reg;
        dclick_cnt_next  = dclick_cnt_reg;
        ev_p = 1'b0;
        ev_r = 1'b0;
        ev_c = 1'b0;
        ev_d = 1'b0;
        ev_l = 1'b0;

        if (in_op_reg == OP_CLEAR)
        begin
            // resync to the present level, zero the statistics
            stable_next      = raw;
            prev_raw_next    = raw;
            pending_raw_next = raw;
            press_cnt_next   = '0;
            release_cnt_next = '0;
            long_cnt_next    = '0;
            dclick_cnt_next  = '0;
            since_press_next = '0;
            since_click_next = SAT16;
        end
        else
        begin
            if (since_press_reg != SAT16)
                since_press_next = since_press_reg + 16'd1;
            if (since_click_reg != SAT16)
                since_click_next = since_click_reg + 16'd1;

            if (raw != prev_raw_reg)
            begin
                // raw change: restart debounce, restart long press on a press
                prev_raw_next    = raw;
                pending_raw_next = raw;
                deb_left_next    = (debounce_ms_reg != 10'd0) ? debounce_ms_reg : 10'd1;
                deb_armed_next   = 1'b1;
                long_armed_next  = raw;
                long_left_next   = raw ? ((long_press_ms_reg != 16'd0) ?
                                          long_press_ms_reg : 16'd1) : 16'd0;
            end
            else
            begin
                if (deb_armed_reg)
                begin
                    deb_left_next = deb_dec;
                    if (deb_dec == 10'd0)
                    begin
                        deb_armed_next = 1'b0;
                        if (raw == pending_raw_reg)
                        begin
                            if (raw != stable_reg)
                            begin
                                stable_next = raw;
                                if (raw)
                                begin
                                    ev_p             = 1'b1;
                                    press_cnt_next   = press_cnt_reg + 32'd1;
                                    since_press_next = '0;
                                end
                                else
                                begin
                                    ev_r             = 1'b1;
                                    release_cnt_next = release_cnt_reg + 32'd1;
                                    if (since_press_next < long_press_ms_reg)
                                    begin
                                        ev_c = 1'b1;
                                        if (since_click_next < double_click_ms_reg)
                                        begin
                                            ev_d            = 1'b1;
                                            dclick_cnt_next = dclick_cnt_reg + 32'd1;
                                        end
                                        since_click_next = '0;
                                    end
                                end
                            end
                        end
                        else
                        begin
                            pending_raw_next = raw;
                        end
                    end
                end
                // long press sees the debounced state after this tick
                if (long_armed_reg)
                begin
                    long_left_next = long_dec;
                    if (long_dec == 16'd0)
                    begin
                        long_armed_next = 1'b0;
                        if (stable_next)
                        begin
                            ev_l          = 1'b1;
                            long_cnt_next = long_cnt_reg + 32'd1;
                        end
                    end
                end
            end
        end

        res                    = '0;
        res.pressed_event      = ev_p && events_enable_reg;
        res.released_event     = ev_r && events_enable_reg;
        res.click_event        = ev_c && events_enable_reg;
        res.double_click_event = ev_d && events_enable_reg;
        res.long_press_event   = ev_l && events_enable_reg;
        res.button_down        = stable_next;
        res.hold_ms            = stable_next ? since_press_next : 16'd0;
        res.press_total        = press_cnt_next;
        res.release_total      = release_cnt_next;
        res.long_press_total   = long_cnt_next;
        res.double_click_total = dclick_cnt_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_raw_reg    <= 1'b0;
            pending_raw_reg <= 1'b0;
            stable_reg      <= 1'b0;
            deb_left_reg    <= '0;
            deb_armed_reg   <= 1'b0;
            long_left_reg   <= '0;
            long_armed_reg  <= 1'b0;
            since_press_reg <= '0;
            since_click_reg <= SAT16;
            press_cnt_reg   <= '0;
            release_cnt_reg <= '0;
            long_cnt_reg    <= '0;
            dclick_cnt_reg  <= '0;
        end
        else if (advance)
        begin
            prev_raw_reg    <= prev_raw_next;
            pending_raw_reg <= pending_raw_next;
            stable_reg      <= stable_next;
            deb_left_reg    <= deb_left_next;
            deb_armed_reg   <= deb_armed_next;
            long_left_reg   <= long_left_next;
            long_armed_reg  <= long_armed_next;
            since_press_reg <= since_press_next;
            since_click_reg <= since_click_next;
            press_cnt_reg   <= press_cnt_next;
            release_cnt_reg <= release_cnt_next;
            long_cnt_reg    <= long_cnt_next;
            dclick_cnt_reg  <= dclick_cnt_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= res;
        end
    end

endmodule

### design/bdgd_checker.sv
// ----------------------------------------------------------------------------
// bdgd_checker: port-level checks for the button debounce detector
// Watches the result stream and flags inconsistent status words.
// ----------------------------------------------------------------------------
module bdgd_checker
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [bdgd_pkg::OUT_DATA_W-1:0] m_tdata
);
    import bdgd_pkg::*;

    result_t word;
    assign word = m_tdata;

    // a stalled word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // a click is always a release
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && word.click_event |-> word.released_event && !word.button_down)
        else $error("click without release");

    // a double click is always a click
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && word.double_click_event |-> word.click_event)
        else $error("double click without click");

    // hold time shows only while pressed, and a press starts it at zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (word.hold_ms != 16'd0 || word.pressed_event) |->
            word.button_down && !(word.pressed_event && word.hold_ms != 16'd0))
        else $error("hold time inconsistent with pressed state");

endmodule

bind button_debounce_gesture_detector bdgd_checker u_bdgd_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
